>>> sv/gain_scheduled_pid_axis_defines.svh
// assertion helpers for the asserting module
`ifndef GAIN_SCHEDULED_PID_AXIS_DEFINES_SVH
`define GAIN_SCHEDULED_PID_AXIS_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define GSP_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("gsp assertion failed");

// next-cycle implication
`define GSP_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("gsp assertion failed");

`endif

>>> sv/gsp_pkg.sv
package gsp_pkg;

    localparam int ERR_W     = 12;
    localparam int DRIVE_W   = 25;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_APP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_LIM  = 3'd7;

    localparam int BLEND_START_PX  = 20;
    localparam int BLEND_END_PX    = 80;
    localparam int GAIN_SLEW_Q16   = 6554;
    localparam int DERIV_ALPHA_Q16 = 19661;
    localparam int OUTPUT_SLEW_Q16 = 65536;

    localparam logic [16:0] BLEND_ONE = 17'h10000;

    // blend range, guarded so an empty range still elaborates
    localparam int BLEND_SPAN  = (BLEND_END_PX > BLEND_START_PX) ?
                                 (BLEND_END_PX - BLEND_START_PX) : 1;
    localparam int BLEND_IDX_W = (BLEND_SPAN > 1) ? $clog2(BLEND_SPAN) : 1;
    localparam int BLEND_DEPTH = 1 << BLEND_IDX_W;

    typedef logic [16:0] t_blend;
    typedef t_blend t_blend_tab [BLEND_DEPTH];

    // smoothstep over the blend range, indexed by |e| - start
    function automatic t_blend_tab build_blend_tab();
        t_blend_tab tab;
        longint     t;
        longint     t2;
        longint     b;
        for (int i = 0; i < BLEND_DEPTH; i++) begin
            t  = (longint'(i) <<< 16) / BLEND_SPAN;
            t2 = (t * t) >>> 16;
            b  = (t2 * (3 * 65536 - 2 * t)) >>> 16;
            tab[i] = t_blend'(b);
        end
        return tab;
    endfunction

    localparam t_blend_tab BLEND_TAB = build_blend_tab();

endpackage

>>> sv/gsp_err_if.sv
interface gsp_err_if;
    logic                            valid;
    logic                            ready;
    logic signed [gsp_pkg::ERR_W-1:0] pixel_error;

    modport source (output valid, output pixel_error, input ready);
    modport sink   (input valid, input pixel_error, output ready);
endinterface

>>> sv/gsp_cmd_if.sv
interface gsp_cmd_if;
    logic                              valid;
    logic                              ready;
    logic signed [gsp_pkg::DRIVE_W-1:0] drive_angle;
    logic                              in_deadband;
    logic                              integral_active;
    logic                              slew_limited;

    modport source (output valid, output drive_angle, output in_deadband,
                    output integral_active, output slew_limited, input ready);
    modport sink   (input valid, input drive_angle, input in_deadband,
                    input integral_active, input slew_limited, output ready);
endinterface

>>> sv/gain_scheduled_pid_axis.sv
// requests are handled one at a time: a new request is accepted only in idle, after
// the previous result has been taken; the one shared 33x25 multiplier serves every
// product in turn, and the deadband path skips the integral, derivative and output steps
// reset: synchronous active low; clears configuration, state, runtime gains and history
`include "gain_scheduled_pid_axis_defines.svh"

module gain_scheduled_pid_axis (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gsp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gsp_pkg::CFG_W-1:0]         i_cfg_data,
    gsp_err_if.sink                           i_err,
    gsp_cmd_if.source                         o_cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ANGLE = 4'd1;
    localparam logic [3:0] ST_G0    = 4'd2;
    localparam logic [3:0] ST_G1    = 4'd3;
    localparam logic [3:0] ST_G2    = 4'd4;
    localparam logic [3:0] ST_PREV  = 4'd5;
    localparam logic [3:0] ST_DRV   = 4'd6;
    localparam logic [3:0] ST_TP    = 4'd7;
    localparam logic [3:0] ST_TI    = 4'd8;
    localparam logic [3:0] ST_TD    = 4'd9;
    localparam logic [3:0] ST_FIN   = 4'd10;
    localparam logic [3:0] ST_FINDB = 4'd11;
    localparam logic [3:0] ST_DONE  = 4'd12;

    // configuration
    logic [31:0] r_kp_pair, r_ki_pair, r_kd_pair;
    logic [15:0] r_app;
    logic [23:0] r_out_lim;
    logic [10:0] r_gate;
    logic [10:0] r_db;
    logic [23:0] r_int_lim;

    // controller state
    logic [23:0]        r_gain [3];
    logic signed [24:0] r_integ;
    logic signed [28:0] r_fd;
    logic signed [11:0] r_prev_e;
    logic signed [24:0] r_prev_out;

    // per-request working registers
    logic [3:0]         r_state;
    logic signed [11:0] r_e;
    logic [11:0]        r_mag;
    logic               r_db_hit;
    logic [16:0]        r_blend;
    logic signed [27:0] r_angle;
    logic [31:0]        r_tacc;
    logic [23:0]        r_tgt;
    logic [1:0]         r_gidx;
    logic signed [28:0] r_draw;
    logic signed [41:0] r_sum;
    logic               r_active;

    // result
    logic signed [24:0] r_drive;
    logic               r_db_out, r_act_out, r_slew_out;

    logic                 accept;
    logic [11:0]          n_mag;
    logic [11:0]          n_off;
    logic [16:0]          n_blend;
    logic [23:0]          gain_cur;
    logic [31:0]          pair_cur;
    logic signed [32:0]   mul_a;
    logic signed [24:0]   mul_b;
    logic signed [57:0]   mul_p;
    logic [32:0]          n_tsum;
    logic signed [28:0]   n_isum;
    logic signed [28:0]   n_ilim;
    logic signed [24:0]   n_integ;
    logic signed [41:0]   n_olim;
    logic signed [41:0]   n_clamped;
    logic signed [41:0]   n_prev;
    logic signed [41:0]   n_delta;
    logic signed [41:0]   n_slew;
    logic signed [41:0]   n_smooth;
    logic signed [41:0]   n_final;
    logic                 n_limited;

    assign accept      = i_err.valid && i_err.ready;
    assign i_err.ready = (r_state == ST_IDLE);

    assign o_cmd.valid           = (r_state == ST_DONE);
    assign o_cmd.drive_angle     = r_drive;
    assign o_cmd.in_deadband     = r_db_out;
    assign o_cmd.integral_active = r_act_out;
    assign o_cmd.slew_limited    = r_slew_out;

    // absolute error and blend lookup at accept
    always_comb begin
        n_mag = i_err.pixel_error[11] ? (~i_err.pixel_error + 12'd1) : i_err.pixel_error;
        n_off = n_mag - 12'(gsp_pkg::BLEND_START_PX);
        if (n_mag <= {1'b0, r_db} || n_mag <= 12'(gsp_pkg::BLEND_START_PX)) begin
            n_blend = '0;
        end else if (n_mag >= 12'(gsp_pkg::BLEND_END_PX)) begin
            n_blend = gsp_pkg::BLEND_ONE;
        end else begin
            n_blend = gsp_pkg::BLEND_TAB[n_off[gsp_pkg::BLEND_IDX_W-1:0]];
        end
    end

    always_comb begin
        case (r_gidx)
            2'd0:    begin gain_cur = r_gain[0]; pair_cur = r_kp_pair; end
            2'd1:    begin gain_cur = r_gain[1]; pair_cur = r_ki_pair; end
            default: begin gain_cur = r_gain[2]; pair_cur = r_kd_pair; end
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_ANGLE: begin
                mul_a = {{21{r_e[11]}}, r_e};
                mul_b = {9'd0, r_app};
            end
            ST_G0: begin
                mul_a = {17'd0, pair_cur[15:0]};
                mul_b = {8'd0, gsp_pkg::BLEND_ONE - r_blend};
            end
            ST_G1: begin
                mul_a = {17'd0, pair_cur[31:16]};
                mul_b = {8'd0, r_blend};
            end
            ST_G2: begin
                mul_a = $signed({9'd0, r_tgt}) - $signed({9'd0, gain_cur});
                mul_b = 25'(gsp_pkg::GAIN_SLEW_Q16);
            end
            ST_PREV: begin
                mul_a = {{21{r_prev_e[11]}}, r_prev_e};
                mul_b = {9'd0, r_app};
            end
            ST_DRV: begin
                mul_a = {{4{r_draw[28]}}, r_draw} - {{4{r_fd[28]}}, r_fd};
                mul_b = 25'(gsp_pkg::DERIV_ALPHA_Q16);
            end
            ST_TP: begin
                mul_a = {{5{r_angle[27]}}, r_angle};
                mul_b = {1'b0, r_gain[0]};
            end
            ST_TI: begin
                mul_a = {{8{r_integ[24]}}, r_integ};
                mul_b = {1'b0, r_gain[1]};
            end
            ST_TD: begin
                mul_a = {{4{r_fd[28]}}, r_fd};
                mul_b = {1'b0, r_gain[2]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign n_tsum = {1'b0, r_tacc} + {1'b0, mul_p[31:0]};

    // integral accumulate and clamp
    always_comb begin
        n_isum = {{4{r_integ[24]}}, r_integ} + {r_angle[27], r_angle};
        n_ilim = {5'd0, r_int_lim};
        if (n_isum > n_ilim) begin
            n_integ = n_ilim[24:0];
        end else if (n_isum < -n_ilim) begin
            n_integ = -n_ilim[24:0];
        end else begin
            n_integ = n_isum[24:0];
        end
    end

    // output clamp, rate limit, clamp again
    always_comb begin
        n_olim = {18'd0, r_out_lim};
        n_slew = 42'(gsp_pkg::OUTPUT_SLEW_Q16);
        n_prev = {{17{r_prev_out[24]}}, r_prev_out};
        if (r_sum > n_olim) begin
            n_clamped = n_olim;
        end else if (r_sum < -n_olim) begin
            n_clamped = -n_olim;
        end else begin
            n_clamped = r_sum;
        end
        n_delta   = n_clamped - n_prev;
        n_limited = 1'b1;
        if (n_delta > n_slew) begin
            n_smooth = n_prev + n_slew;
        end else if (n_delta < -n_slew) begin
            n_smooth = n_prev - n_slew;
        end else begin
            n_smooth  = n_clamped;
            n_limited = 1'b0;
        end
        if (n_smooth > n_olim) begin
            n_final = n_olim;
        end else if (n_smooth < -n_olim) begin
            n_final = -n_olim;
        end else begin
            n_final = n_smooth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_pair  <= '0;
            r_ki_pair  <= '0;
            r_kd_pair  <= '0;
            r_app      <= '0;
            r_out_lim  <= '0;
            r_gate     <= '0;
            r_db       <= '0;
            r_int_lim  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gsp_pkg::CFG_KP:       r_kp_pair <= i_cfg_data;
                gsp_pkg::CFG_KI:       r_ki_pair <= i_cfg_data;
                gsp_pkg::CFG_KD:       r_kd_pair <= i_cfg_data;
                gsp_pkg::CFG_APP:      r_app     <= i_cfg_data[15:0];
                gsp_pkg::CFG_OUT_LIM:  r_out_lim <= i_cfg_data[23:0];
                gsp_pkg::CFG_GATE:     r_gate    <= i_cfg_data[10:0];
                gsp_pkg::CFG_DEADBAND: r_db      <= i_cfg_data[10:0];
                gsp_pkg::CFG_INT_LIM:  r_int_lim <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_gain[0]  <= '0;
            r_gain[1]  <= '0;
            r_gain[2]  <= '0;
            r_integ    <= '0;
            r_fd       <= '0;
            r_prev_e   <= '0;
            r_prev_out <= '0;
            r_gidx     <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_e      <= i_err.pixel_error;
                        r_mag    <= n_mag;
                        r_db_hit <= (n_mag <= {1'b0, r_db});
                        r_blend  <= n_blend;
                        r_gidx   <= '0;
                        r_state  <= ST_ANGLE;
                    end
                end
                ST_ANGLE: begin
                    r_angle <= mul_p[27:0];
                    r_state <= ST_G0;
                end
                ST_G0: begin
                    r_tacc  <= mul_p[31:0];
                    r_state <= ST_G1;
                end
                ST_G1: begin
                    r_tgt   <= n_tsum[31:8];
                    r_state <= ST_G2;
                end
                ST_G2: begin
                    case (r_gidx)
                        2'd0:    r_gain[0] <= gain_cur + mul_p[39:16];
                        2'd1:    r_gain[1] <= gain_cur + mul_p[39:16];
                        default: r_gain[2] <= gain_cur + mul_p[39:16];
                    endcase
                    if (r_gidx == 2'd2) begin
                        r_state <= r_db_hit ? ST_FINDB : ST_PREV;
                    end else begin
                        r_gidx  <= r_gidx + 2'd1;
                        r_state <= ST_G0;
                    end
                end
                ST_PREV: begin
                    if (r_mag > {1'b0, r_gate}) begin
                        r_integ  <= '0;
                        r_active <= 1'b0;
                    end else begin
                        r_integ  <= n_integ;
                        r_active <= 1'b1;
                    end
                    r_draw  <= {r_angle[27], r_angle} - mul_p[28:0];
                    r_state <= ST_DRV;
                end
                ST_DRV: begin
                    r_fd    <= r_fd + mul_p[44:16];
                    r_state <= ST_TP;
                end
                ST_TP: begin
                    r_sum   <= mul_p[57:16];
                    r_state <= ST_TI;
                end
                ST_TI: begin
                    r_sum   <= r_sum + mul_p[57:16];
                    r_state <= ST_TD;
                end
                ST_TD: begin
                    r_sum   <= r_sum + mul_p[57:16];
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    r_drive    <= n_final[24:0];
                    r_db_out   <= 1'b0;
                    r_act_out  <= r_active;
                    r_slew_out <= n_limited;
                    r_prev_out <= n_final[24:0];
                    r_prev_e   <= r_e;
                    r_state    <= ST_DONE;
                end
                ST_FINDB: begin
                    r_integ    <= '0;
                    r_fd       <= '0;
                    r_prev_e   <= '0;
                    r_prev_out <= '0;
                    r_drive    <= '0;
                    r_db_out   <= 1'b1;
                    r_act_out  <= 1'b0;
                    r_slew_out <= 1'b0;
                    r_state    <= ST_DONE;
                end
                ST_DONE: begin
                    if (o_cmd.ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `GSP_ASSERT_IMP(a_no_overlap, o_cmd.valid, !i_err.ready)
    `GSP_ASSERT_NXT(a_busy_after_accept, accept, !i_err.ready && !o_cmd.valid)
    `GSP_ASSERT_IMP(a_deadband_zero, o_cmd.valid && o_cmd.in_deadband,
                    o_cmd.drive_angle == '0 && !o_cmd.integral_active && !o_cmd.slew_limited)
    `GSP_ASSERT_IMP(a_drive_in_limit, o_cmd.valid,
                    o_cmd.drive_angle <= $signed({1'b0, r_out_lim}) &&
                    o_cmd.drive_angle >= -$signed({1'b0, r_out_lim}))

endmodule

>>> bench/tb.sv
module tb;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [gsp_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [gsp_pkg::CFG_W-1:0] i_cfg_data;

    gsp_err_if err_ch ();
    gsp_cmd_if cmd_ch ();

    gain_scheduled_pid_axis uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_err(err_ch.sink), .o_cmd(cmd_ch.source)
    );

    typedef logic signed [gsp_pkg::ERR_W-1:0] t_px;

    typedef struct packed {
        logic signed [gsp_pkg::DRIVE_W-1:0] angle;
        logic deadband;
        logic integ;
        logic limited;
    } t_cmd;

    // controller copy
    logic [31:0] kp_pair, ki_pair, kd_pair;
    longint app, out_lim, gate, dead, int_lim;
    longint rt_kp, rt_ki, rt_kd, isum, dfilt, prev_e, prev_out;

    t_cmd cmd_q[$];
    int errors;
    int n_cmds;
    int send_idle_pct;
    int recv_stall_pct;
    longint cycles;

    // directed rows: error plus an optional typed-in result
    typedef struct {
        int err;
        bit known;
        t_cmd want;
    } t_row;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint fshift(longint v);
        return v >>> 16;
    endfunction

    function automatic longint clamp(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint blend_for(longint mag);
        longint t;
        longint t2;
        if (mag <= gsp_pkg::BLEND_START_PX) return 0;
        if (mag >= gsp_pkg::BLEND_END_PX) return 65536;
        t = (mag - gsp_pkg::BLEND_START_PX) * 65536 /
            (gsp_pkg::BLEND_END_PX - gsp_pkg::BLEND_START_PX);
        t2 = (t * t) >> 16;
        return (t2 * (3 * 65536 - 2 * t)) >> 16;
    endfunction

    function automatic longint slew_toward(longint rt, logic [31:0] pair, longint b);
        longint sm;
        longint lg;
        longint tgt;
        sm = pair[15:0];
        lg = pair[31:16];
        tgt = (sm * (65536 - b) + lg * b) >> 8;
        rt = rt + fshift((tgt - rt) * gsp_pkg::GAIN_SLEW_Q16);
        return rt & 24'hFFFFFF;
    endfunction

    function automatic void retune(longint mag);
        longint b;
        b = blend_for(mag);
        rt_kp = slew_toward(rt_kp, kp_pair, b);
        rt_ki = slew_toward(rt_ki, ki_pair, b);
        rt_kd = slew_toward(rt_kd, kd_pair, b);
    endfunction

    function automatic t_cmd pid_step(t_px px);
        t_cmd r;
        longint e;
        longint mag;
        longint ang;
        longint sum;
        longint dlt;
        longint sm;
        e = px;
        mag = e < 0 ? -e : e;
        r = '0;
        if (mag <= dead) begin
            retune(0);
            isum = 0; dfilt = 0; prev_e = 0; prev_out = 0;
            r.deadband = 1'b1;
            return r;
        end
        ang = e * app;
        retune(mag);
        if (mag > gate) begin
            isum = 0;
        end else begin
            isum = clamp(isum + ang, int_lim);
            r.integ = 1'b1;
        end
        dfilt = dfilt + fshift((ang - prev_e * app - dfilt) * gsp_pkg::DERIV_ALPHA_Q16);
        sum = fshift(rt_kp * ang) + fshift(rt_ki * isum) + fshift(rt_kd * dfilt);
        sum = clamp(sum, out_lim);
        dlt = sum - prev_out;
        if (dlt > gsp_pkg::OUTPUT_SLEW_Q16) begin
            sm = prev_out + gsp_pkg::OUTPUT_SLEW_Q16;
            r.limited = 1'b1;
        end else if (dlt < -gsp_pkg::OUTPUT_SLEW_Q16) begin
            sm = prev_out - gsp_pkg::OUTPUT_SLEW_Q16;
            r.limited = 1'b1;
        end else begin
            sm = sum;
        end
        sm = clamp(sm, out_lim);
        prev_e = e;
        prev_out = sm;
        r.angle = sm[gsp_pkg::DRIVE_W-1:0];
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        errors++;
        $display("tb: mismatch %s got %0d want %0d (result %0d)", what, got, want, n_cmds);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_cmd w;
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            if (cmd_q.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                w = cmd_q.pop_front();
                if (cmd_ch.drive_angle !== w.angle)
                    report("drive_angle", cmd_ch.drive_angle, w.angle);
                if (cmd_ch.in_deadband !== w.deadband)
                    report("in_deadband", cmd_ch.in_deadband, w.deadband);
                if (cmd_ch.integral_active !== w.integ)
                    report("integral_active", cmd_ch.integral_active, w.integ);
                if (cmd_ch.slew_limited !== w.limited)
                    report("slew_limited", cmd_ch.slew_limited, w.limited);
            end
            n_cmds++;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        cmd_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (cycles > 3000000) begin
            $display("tb: timeout");
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic cfg_write(logic [gsp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            gsp_pkg::CFG_KP: kp_pair = val;
            gsp_pkg::CFG_KI: ki_pair = val;
            gsp_pkg::CFG_KD: kd_pair = val;
            gsp_pkg::CFG_APP: app = val[15:0];
            gsp_pkg::CFG_OUT_LIM: out_lim = val[23:0];
            gsp_pkg::CFG_GATE: gate = val[10:0];
            gsp_pkg::CFG_DEADBAND: dead = val[10:0];
            gsp_pkg::CFG_INT_LIM: int_lim = val[23:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (cmd_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // one request; a fixed want overrides the prediction after it is computed
    task automatic send(t_px px, bit known, t_cmd want);
        t_cmd p;
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        err_ch.valid <= 1'b1;
        err_ch.pixel_error <= px;
        @(posedge i_clk);
        while (!err_ch.ready) @(posedge i_clk);
        p = pid_step(px);
        cmd_q.push_back(known ? want : p);
        err_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_px rand_err();
        int k;
        k = $urandom_range(9);
        if (k < 4) return t_px'($urandom_range(160) - 80);
        if (k < 6) return t_px'($urandom_range(30) - 15);
        return t_px'($urandom);
    endfunction

    task automatic rand_config(bit extreme);
        cfg_write(gsp_pkg::CFG_KP, extreme ? 32'hFFFF_FFFF : $urandom & 32'h0FFF_0FFF);
        cfg_write(gsp_pkg::CFG_KI, extreme ? 32'hFFFF_FFFF : $urandom & 32'h01FF_01FF);
        cfg_write(gsp_pkg::CFG_KD, extreme ? 32'hFFFF_FFFF : $urandom & 32'h0FFF_0FFF);
        cfg_write(gsp_pkg::CFG_APP, extreme ? 32'hFFFF : $urandom_range(65535));
        cfg_write(gsp_pkg::CFG_OUT_LIM, extreme ? 32'hFFFFFF : $urandom_range(11796480));
        cfg_write(gsp_pkg::CFG_GATE, extreme ? 32'h7FF : $urandom_range(300));
        cfg_write(gsp_pkg::CFG_DEADBAND, extreme ? 32'd0 : $urandom_range(12));
        cfg_write(gsp_pkg::CFG_INT_LIM, extreme ? 32'hFFFFFF : $urandom_range(11796480));
    endtask

    initial begin
        t_row rows[$];
        int dir_err [22];
        t_cmd z;
        t_cmd db;
        errors = 0; n_cmds = 0; cycles = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        kp_pair = 0; ki_pair = 0; kd_pair = 0;
        app = 0; out_lim = 0; gate = 0; dead = 0; int_lim = 0;
        rt_kp = 0; rt_ki = 0; rt_kd = 0;
        isum = 0; dfilt = 0; prev_e = 0; prev_out = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        err_ch.valid = 1'b0; err_ch.pixel_error = '0;
        cmd_ch.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: zero error sits in the deadband, others give zero drive
        z = '0;
        db = '0; db.deadband = 1'b1;
        rows.push_back('{0, 1, db});
        z.integ = 1'b0;
        rows.push_back('{2047, 1, z});
        rows.push_back('{-2048, 1, z});
        foreach (rows[i]) send(t_px'(rows[i].err), rows[i].known, rows[i].want);
        drain();

        cfg_write(gsp_pkg::CFG_KP, 32'h0400_0100);
        cfg_write(gsp_pkg::CFG_KI, 32'h0020_0010);
        cfg_write(gsp_pkg::CFG_KD, 32'h0200_0080);
        cfg_write(gsp_pkg::CFG_APP, 32'd3000);
        cfg_write(gsp_pkg::CFG_OUT_LIM, 32'd11796480);
        cfg_write(gsp_pkg::CFG_GATE, 32'd100);
        cfg_write(gsp_pkg::CFG_DEADBAND, 32'd5);
        cfg_write(gsp_pkg::CFG_INT_LIM, 32'd200000);
        rows.delete();
        // deadband edge, blend start/end edges, gate edges, sign extremes
        dir_err = '{5, -5, 6, -6, 20, 21, 50, 79, 80, 81, 100, 101, -101, 2047,
                    -2048, 1, 30, 30, 30, -40, 0, 500};
        foreach (dir_err[i]) rows.push_back('{dir_err[i], 0, z});
        foreach (rows[i]) send(t_px'(rows[i].err), rows[i].known, rows[i].want);
        drain();
        cfg_write(gsp_pkg::CFG_INT_LIM, 32'd200000);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 70; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 70; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            rand_config(ph == 4);
            for (int n = 0; n < 220; n++) begin
                send(rand_err(), 0, z);
                if (n == 110) begin
                    // hold off until every result has come back
                    while (cmd_q.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end
        send_idle_pct = 0; recv_stall_pct = 0;
        cfg_write(gsp_pkg::CFG_DEADBAND, 32'h7FF);
        cfg_write(gsp_pkg::CFG_GATE, 32'd0);
        for (int n = 0; n < 10; n++) send(t_px'($urandom), 0, z);
        drain();

        $display("tb: %0d results checked over six gain and limit settings,", n_cmds);
        $display("tb: deadband, blend, gate, clamp and rate-limit edges included");
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

>>> gain_scheduled_pid_axis.f
+incdir+sv
sv/gsp_pkg.sv
sv/gsp_err_if.sv
sv/gsp_cmd_if.sv
sv/gain_scheduled_pid_axis.sv
bench/tb.sv
